/* rtl/stb_pkg.sv */
// Shared types and constants of the software timer bank.
`timescale 1ns / 1ps
package stb_pkg;

  localparam int OP_W      = 3;
  localparam int TIME_W    = 32;
  localparam int ID_W      = 5;
  localparam int SLOT_W    = 5;
  localparam int KIND_W    = 2;
  localparam int TICK_W    = 8;
  localparam int MAX_SLOTS = 32;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_TICK    = 3'd3,
    OP_SERVICE = 3'd4
  } stb_op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_EVENT  = 2'd2,
    KIND_NONE   = 2'd3
  } stb_kind_t;

  typedef enum logic [1:0] {
    RSEL_CREATE,
    RSEL_ACK,
    RSEL_EVENT,
    RSEL_NONE
  } stb_rsel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_CRT_DONE,
    S_TICK,
    S_REPLY,
    S_SVC
  } stb_state_t;

  typedef struct packed {
    logic      load;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      div_step;
    logic      crt_commit;
    logic      ctl_commit;
    logic      tick_proc;
    logic      svc_clear;
    logic      push;
    stb_rsel_t rsel;
  } stb_cmd_t;

  typedef struct packed {
    stb_op_t op;
    logic    cnt_zero;
    logic    div_end;
    logic    walk_end;
    logic    pend_any;
    logic    pend_here;
    logic    pend_last;
    logic    out_free;
  } stb_status_t;

endpackage

/* rtl/stb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/stb_ctrl.sv */
// Controller state machine of the software timer bank.
`timescale 1ns / 1ps
module stb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  stb_pkg::stb_status_t status,
  output logic                in_tready,
  output stb_pkg::stb_cmd_t   cmd
);
  import stb_pkg::*;

  stb_state_t state_r;
  stb_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (status.op)
            OP_CREATE:  state_nxt = S_CREATE;
            OP_TICK:    state_nxt = S_TICK;
            OP_SERVICE: state_nxt = S_SVC;
            default:    state_nxt = S_REPLY;
          endcase
        end
      end
      S_CREATE: begin
        if (status.div_end) state_nxt = S_CRT_DONE;
      end
      S_CRT_DONE: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      S_TICK: begin
        if (status.walk_end) state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      S_SVC: begin
        if (!status.pend_any) begin
          if (status.out_free) state_nxt = S_IDLE;
        end else if (status.pend_here && status.out_free && status.pend_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.rsel  = RSEL_ACK;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load    = in_tvalid;
        cmd.cnt_clr = in_tvalid;
      end
      S_CREATE: begin
        cmd.div_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      S_CRT_DONE: begin
        cmd.rsel       = RSEL_CREATE;
        cmd.push       = status.out_free;
        cmd.crt_commit = status.out_free;
      end
      S_TICK: begin
        cmd.cnt_inc   = 1'b1;
        // slot idx-1 has its counts on the RAM outputs
        cmd.tick_proc = !status.cnt_zero;
      end
      S_REPLY: begin
        cmd.rsel       = RSEL_ACK;
        cmd.push       = status.out_free;
        cmd.ctl_commit = status.out_free;
      end
      S_SVC: begin
        if (!status.pend_any) begin
          cmd.rsel = RSEL_NONE;
          cmd.push = status.out_free;
        end else if (status.pend_here) begin
          cmd.rsel      = RSEL_EVENT;
          cmd.push      = status.out_free;
          cmd.svc_clear = status.out_free;
          cmd.cnt_inc   = status.out_free && !status.pend_last;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/stb_dp.sv */
// Datapath of the software timer bank: slot flags, count RAMs, divider, result register.
`timescale 1ns / 1ps
module stb_dp #(
  parameter int BANK_SLOTS = 32,
  parameter int SW         = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wen,
  input  logic [stb_pkg::TICK_W-1:0]          cfg_wdata,
  input  logic [stb_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [stb_pkg::OP_W-1:0]            in_tuser,
  input  stb_pkg::stb_cmd_t                   cmd,
  output stb_pkg::stb_status_t                status,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [stb_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [stb_pkg::KIND_W-1:0]          out_tuser,
  output logic                                out_tlast
);
  import stb_pkg::*;

  // configuration
  logic [TICK_W-1:0] tick_ms_r;
  logic [TICK_W-1:0] divisor;

  // latched item
  stb_op_t           op_r;
  logic              per_r;
  logic [ID_W-1:0]   id_r;

  // walk counter and divider
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  idx_m1;
  logic [SW-1:0]     sidx;
  logic [SW-1:0]     pidx;
  logic [TICK_W-1:0] rem_r;
  logic [TIME_W-1:0] quo_r;
  logic [TICK_W+1:0] diff;
  logic              found_r;
  logic [SW-1:0]     fslot_r;

  // slot flags
  logic [BANK_SLOTS-1:0] used_r;
  logic [BANK_SLOTS-1:0] periodic_r;
  logic [BANK_SLOTS-1:0] running_r;
  logic [BANK_SLOTS-1:0] expired_r;
  logic [BANK_SLOTS-1:0] pend;
  logic [BANK_SLOTS-1:0] pend_rest;

  // count memories
  logic              cur_we;
  logic [SW-1:0]     cur_waddr;
  logic [TIME_W-1:0] cur_wdata;
  logic [TIME_W-1:0] cur_rd;
  logic [TIME_W-1:0] rel_rd;
  logic              rel_we;
  logic              tick_act;
  logic              cur_zero;

  logic              id_ok;
  logic              in_range;

  // result register
  logic              out_valid_r;
  stb_kind_t         kind_r;
  logic [SLOT_W-1:0] slot_r;
  logic              ok_r;
  logic              last_r;
  logic              out_free;

  assign divisor = (tick_ms_r == '0) ? TICK_W'(1) : tick_ms_r;
  assign idx_m1  = idx_r - CNT_W'(1);
  assign sidx    = idx_r[SW-1:0];
  assign pidx    = idx_m1[SW-1:0];
  assign in_range = idx_r < CNT_W'(BANK_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_ms_r <= TICK_W'(1);
    end else if (cfg_wen) begin
      tick_ms_r <= cfg_wdata;
    end
  end

  // hold the item fields for the whole operation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= stb_op_t'(in_tuser);
      per_r <= in_tdata[0];
      id_r  <= in_tdata[TIME_W+ID_W:TIME_W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.cnt_clr) begin
      idx_r <= '0;
    end else if (cmd.cnt_inc) begin
      idx_r <= idx_r + CNT_W'(1);
    end
  end

  // restoring division, one quotient bit a cycle
  assign diff = {1'b0, rem_r, quo_r[TIME_W-1]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= '0;
      quo_r <= in_tdata[TIME_W:1];
    end else if (cmd.div_step) begin
      if (!diff[TICK_W+1]) begin
        rem_r <= diff[TICK_W-1:0];
      end else begin
        rem_r <= {rem_r[TICK_W-2:0], quo_r[TIME_W-1]};
      end
      quo_r <= {quo_r[TIME_W-2:0], !diff[TICK_W+1]};
    end
  end

  // scan for the lowest free slot alongside the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
    end else if (cmd.div_step && in_range && !used_r[sidx] && !found_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && in_range && !used_r[sidx] && !found_r) begin
      fslot_r <= sidx;
    end
  end

  assign id_ok = ({1'b0, id_r} < CNT_W'(BANK_SLOTS)) && used_r[id_r[SW-1:0]];

  assign tick_act = cmd.tick_proc && used_r[pidx] && running_r[pidx];
  assign cur_zero = (cur_rd == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      periodic_r <= '0;
      running_r  <= '0;
      expired_r  <= '0;
    end else begin
      if (cmd.crt_commit && found_r) begin
        used_r[fslot_r]     <= 1'b1;
        periodic_r[fslot_r] <= per_r;
        running_r[fslot_r]  <= 1'b0;
        expired_r[fslot_r]  <= 1'b0;
      end
      if (cmd.ctl_commit && id_ok && (op_r == OP_START || op_r == OP_STOP)) begin
        running_r[id_r[SW-1:0]] <= (op_r == OP_START);
      end
      if (tick_act) begin
        if (cur_zero) begin
          if (!periodic_r[pidx]) running_r[pidx] <= 1'b0;
        end else if (cur_rd == TIME_W'(1)) begin
          expired_r[pidx] <= 1'b1;
        end
      end
      if (cmd.svc_clear) begin
        expired_r[sidx] <= 1'b0;
      end
    end
  end

  // count RAM writes: create fills a slot, tick updates the walked slot
  assign rel_we    = cmd.crt_commit && found_r;
  assign cur_we    = rel_we || (tick_act && !(cur_zero && !periodic_r[pidx]));
  assign cur_waddr = cmd.crt_commit ? fslot_r : pidx;
  always_comb begin
    if (cmd.crt_commit) begin
      cur_wdata = quo_r;
    end else if (cur_zero) begin
      cur_wdata = rel_rd;
    end else begin
      cur_wdata = cur_rd - TIME_W'(1);
    end
  end

  stb_ram #(
    .WIDTH(TIME_W),
    .DEPTH(BANK_SLOTS)
  ) u_cur_ram (
    .clk  (clk),
    .we   (cur_we),
    .waddr(cur_waddr),
    .wdata(cur_wdata),
    .raddr(sidx),
    .rdata(cur_rd)
  );

  stb_ram #(
    .WIDTH(TIME_W),
    .DEPTH(BANK_SLOTS)
  ) u_rel_ram (
    .clk  (clk),
    .we   (rel_we),
    .waddr(fslot_r),
    .wdata(quo_r),
    .raddr(sidx),
    .rdata(rel_rd)
  );

  // expired slots still to report; events clear as they go out
  assign pend = used_r & expired_r;
  always_comb begin
    pend_rest = pend;
    if (in_range) pend_rest[sidx] = 1'b0;
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      case (cmd.rsel)
        RSEL_CREATE: begin
          kind_r <= KIND_CREATE;
          slot_r <= found_r ? SLOT_W'(fslot_r) : '0;
          ok_r   <= found_r;
          last_r <= 1'b1;
        end
        RSEL_EVENT: begin
          kind_r <= KIND_EVENT;
          slot_r <= SLOT_W'(sidx);
          ok_r   <= 1'b1;
          last_r <= (pend_rest == '0);
        end
        RSEL_NONE: begin
          kind_r <= KIND_NONE;
          slot_r <= '0;
          ok_r   <= 1'b0;
          last_r <= 1'b1;
        end
        default: begin
          kind_r <= KIND_ACK;
          slot_r <= '0;
          ok_r   <= (op_r == OP_TICK) ||
                    ((op_r == OP_START || op_r == OP_STOP) && id_ok);
          last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-SLOT_W-1){1'b0}}, ok_r, slot_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  always_comb begin
    status           = '0;
    status.op        = stb_op_t'(in_tuser);
    status.cnt_zero  = (idx_r == '0);
    status.div_end   = (idx_r == CNT_W'(DIV_STEPS - 1));
    status.walk_end  = (idx_r == CNT_W'(BANK_SLOTS));
    status.pend_any  = (pend != '0);
    status.pend_here = in_range && pend[sidx];
    status.pend_last = (pend_rest == '0);
    status.out_free  = out_free;
  end

endmodule

/* rtl/software_timer_bank_core.sv */
// Software timer bank: slot allocation, start/stop, tick walk and expiry service.
// Operation: start/stop/unknown op pass through S_REPLY to the result register; create runs
// a 32-step divider with a free-slot scan in step; tick walks one slot a cycle through
// the count RAM; service visits the slots in order and can stall on the output.
// Throughput: one item at a time, the next taken once the last result is registered.
// Reset (rst_n low, synchronous): slot flags clear, tick_ms becomes 1, count RAMs untouched.
`timescale 1ns / 1ps
module software_timer_bank_core #(
  parameter int NUM_TIMERS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wen,
  input  logic [stb_pkg::TICK_W-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // periodic [0], time_ms [32:1], timer_id [37:33], zero [39:38]
  input  logic [stb_pkg::IN_DATA_W-1:0]      in_tdata,
  // op [2:0]
  input  logic [stb_pkg::OP_W-1:0]           in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // slot [4:0], ok [5], zero [7:6]
  output logic [stb_pkg::OUT_DATA_W-1:0]     out_tdata,
  // kind [1:0]
  output logic [stb_pkg::KIND_W-1:0]         out_tuser,
  output logic                               out_tlast
);
  import stb_pkg::*;

  localparam int BANK_SLOTS = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
  localparam int SW         = (BANK_SLOTS > 1) ? $clog2(BANK_SLOTS) : 1;

  stb_cmd_t    cmd;
  stb_status_t status;

  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .status   (status),
    .in_tready(in_tready),
    .cmd      (cmd)
  );

  stb_dp #(
    .BANK_SLOTS(BANK_SLOTS),
    .SW        (SW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
